>>> design/flu_pkg.sv
// Shared types, constants and arithmetic helpers for the field map lookup unit.
package flu_pkg;

  localparam int STORE_AW = 15;
  localparam int SAMPLE_W = 32;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_INV_X    = 3'd3;
  localparam logic [2:0] CFG_INV_Y    = 3'd4;
  localparam logic [2:0] CFG_INV_Z    = 3'd5;
  localparam logic [2:0] CFG_SCALE    = 3'd6;

  typedef enum logic [1:0] {
    E_LOAD,
    E_QUERY,
    E_OUTSIDE
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t           kind;
    logic [STORE_AW-1:0]   addr;
    logic [3*SAMPLE_W-1:0] sample;
    logic [15:0]           fx;
    logic [15:0]           fy;
    logic [15:0]           fz;
  } entry_t;

  typedef struct packed {
    logic [2:0][31:0] origin;
    logic [2:0][31:0] inv_step;
  } geom_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SUB,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_SCALE,
    B_OUT
  } back_state_t;

  // a + floor((b - a) * f / 2^16), equal to floor((a*(2^16-f) + b*f) / 2^16)
  function automatic logic [31:0] lerp(input logic [31:0] a, input logic [31:0] b,
                                       input logic [15:0] f);
    logic signed [32:0] diff;
    logic signed [49:0] prod;
    logic signed [49:0] sum;
    diff = $signed({b[31], b}) - $signed({a[31], a});
    prod = diff * $signed({1'b0, f});
    sum  = (prod >>> 16) + $signed({{18{a[31]}}, a});
    return sum[31:0];
  endfunction

endpackage

>>> design/field_map_trilinear_lookup_unit.sv
// A query passes the front, the two-entry queue and the back; a load gives no result.
// Front: subtract, 32x32 multiply per axis and classify for a query; a load is passed on.
// Back: eight corner reads from the single sample memory port plus blend and scale
// steps per in-grid query; one write per load. The front takes a new word only when idle.
// Sync active-low reset clears control and geometry registers and sets the scale register
// to 32'h0001_0000; the sample store is not cleared and must be loaded first.
module field_map_trilinear_lookup_unit #(
  parameter int GRID_NX = 32,
  parameter int GRID_NY = 32,
  parameter int GRID_NZ = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [14:0]        in_load_index,
  input  logic signed [31:0] in_load_bx,
  input  logic signed [31:0] in_load_by,
  input  logic signed [31:0] in_load_bz,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_field_x,
  output logic signed [31:0] out_field_y,
  output logic signed [31:0] out_field_z,
  output logic               out_in_grid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import flu_pkg::*;

  geom_t       geom_r;
  logic [31:0] scale_r;

  logic   push, pop, full, empty;
  entry_t push_data, head;

  // config writes are always taken; index 7 writes nothing
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r  <= '0;
      scale_r <= 32'h0001_0000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: geom_r.origin[0]   <= cfg_data;
        CFG_ORIGIN_Y: geom_r.origin[1]   <= cfg_data;
        CFG_ORIGIN_Z: geom_r.origin[2]   <= cfg_data;
        CFG_INV_X:    geom_r.inv_step[0] <= cfg_data;
        CFG_INV_Y:    geom_r.inv_step[1] <= cfg_data;
        CFG_INV_Z:    geom_r.inv_step[2] <= cfg_data;
        CFG_SCALE:    scale_r            <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: classify and map positions
  flu_front #(.GRID_NX(GRID_NX), .GRID_NY(GRID_NY), .GRID_NZ(GRID_NZ)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .geom          (geom_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_load_index (in_load_index),
    .in_load_bx    (in_load_bx),
    .in_load_by    (in_load_by),
    .in_load_bz    (in_load_bz),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .push          (push),
    .push_data     (push_data),
    .fifo_full     (full)
  );

  // decoupling queue; loads and queries stay in order so memory writes stay ordered
  flu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // back: memory access, blending, scaling and output word register
  flu_back #(.GRID_NX(GRID_NX), .GRID_NY(GRID_NY)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .scale_factor (scale_r),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_field_x  (out_field_x),
    .out_field_y  (out_field_y),
    .out_field_z  (out_field_z),
    .out_in_grid  (out_in_grid)
  );

endmodule

>>> design/flu_ram.sv
// Generic single-port RAM with registered read.
module flu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/flu_fifo.sv
// Two-entry queue between the front and back parts.
module flu_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  flu_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output flu_pkg::entry_t head,
  output logic            empty
);
  import flu_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/flu_front.sv
// Front part: accepts words, maps query positions to cells and classifies them.
module flu_front #(
  parameter int GRID_NX = 32,
  parameter int GRID_NY = 32,
  parameter int GRID_NZ = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  flu_pkg::geom_t         geom,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_req_type,
  input  logic [14:0]            in_load_index,
  input  logic signed [31:0]     in_load_bx,
  input  logic signed [31:0]     in_load_by,
  input  logic signed [31:0]     in_load_bz,
  input  logic signed [31:0]     in_pos_x,
  input  logic signed [31:0]     in_pos_y,
  input  logic signed [31:0]     in_pos_z,
  output logic                   push,
  output flu_pkg::entry_t        push_data,
  input  logic                   fifo_full
);
  import flu_pkg::*;

  localparam int DY = GRID_NX;
  localparam int DZ = GRID_NX * GRID_NY;

  front_state_t     state_r, state_nxt;
  logic             is_load_r;
  logic [14:0]      index_r;
  logic [95:0]      sample_r;
  logic [2:0][31:0] pos_r;
  logic [2:0][32:0] d_r;
  logic [2:0][63:0] prod_r;
  logic [2:0]       ok_r;

  logic [2:0][15:0] cell_idx;
  logic             in_range;
  logic [31:0]      base_w;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_valid) state_nxt = in_req_type ? F_SUB : F_PUSH;
      F_SUB:   state_nxt = F_MUL;
      F_MUL:   state_nxt = F_PUSH;
      F_PUSH:  if (!fifo_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = state_r != F_IDLE;
    push     = (state_r == F_PUSH) && !fifo_full;
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cell_idx[a] = prod_r[a][63:48];
    end
    in_range = (&ok_r) && (cell_idx[0] <= 16'(GRID_NX - 2))
               && (cell_idx[1] <= 16'(GRID_NY - 2)) && (cell_idx[2] <= 16'(GRID_NZ - 2));
    base_w = 32'(cell_idx[0]) + 32'(DY) * 32'(cell_idx[1]) + 32'(DZ) * 32'(cell_idx[2]);
    push_data.kind   = is_load_r ? E_LOAD : (in_range ? E_QUERY : E_OUTSIDE);
    push_data.addr   = is_load_r ? index_r : base_w[STORE_AW-1:0];
    push_data.sample = sample_r;
    push_data.fx     = prod_r[0][47:32];
    push_data.fy     = prod_r[1][47:32];
    push_data.fz     = prod_r[2][47:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          is_load_r <= !in_req_type;
          index_r   <= in_load_index;
          sample_r  <= {in_load_bz, in_load_by, in_load_bx};
          pos_r     <= {in_pos_z, in_pos_y, in_pos_x};
        end
      end
      F_SUB: begin
        for (int a = 0; a < 3; a++) begin
          d_r[a] <= {pos_r[a][31], pos_r[a]} - {geom.origin[a][31], geom.origin[a]};
        end
      end
      F_MUL: begin
        // negative offset lies outside unless the inverse step is zero
        for (int a = 0; a < 3; a++) begin
          ok_r[a]   <= !d_r[a][32] || (geom.inv_step[a] == 32'd0);
          prod_r[a] <= d_r[a][32] ? 64'd0 : 64'(d_r[a][31:0]) * 64'(geom.inv_step[a]);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/flu_back.sv
// Back part: writes samples, reads eight corners, blends, scales and holds the result.
module flu_back #(
  parameter int GRID_NX = 32,
  parameter int GRID_NY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        scale_factor,
  input  flu_pkg::entry_t    head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_field_x,
  output logic signed [31:0] out_field_y,
  output logic signed [31:0] out_field_z,
  output logic               out_in_grid
);
  import flu_pkg::*;

  localparam logic [STORE_AW-1:0] DY = STORE_AW'(GRID_NX);
  localparam logic [STORE_AW-1:0] DZ = STORE_AW'(GRID_NX * GRID_NY);

  back_state_t         state_r, state_nxt;
  logic [3:0]          cnt_r;
  logic [STORE_AW-1:0] base_r;
  logic [15:0]         fx_r, fy_r, fz_r;
  logic [2:0][31:0]    hold_r, x00_r, x10_r, x01_r, x11_r, y0_r, y1_r, v_r;
  logic [2:0][64:0]    prod_r;
  logic                grid_r;
  logic                out_valid_r;
  logic [2:0][31:0]    res_r;

  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [95:0]         ram_q;
  logic [2:0][31:0]    q;
  logic [2:0][31:0]    la, lb, ly;
  logic [15:0]         lf;
  logic                out_free;
  logic [32:0]         neg_scale;
  logic [2:0][64:0]    shifted;
  logic [2:0][31:0]    sat;

  flu_ram #(.WIDTH(3 * SAMPLE_W), .DEPTH(2 ** STORE_AW)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (head.sample),
    .rdata (ram_q)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign neg_scale = 33'd0 - {scale_factor[31], scale_factor};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!empty && head.kind == E_QUERY) state_nxt = B_RUN;
        else if (!empty && head.kind == E_OUTSIDE) state_nxt = B_OUT;
      end
      B_RUN:   if (cnt_r == 4'd10) state_nxt = B_SCALE;
      B_SCALE: state_nxt = B_OUT;
      B_OUT:   if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state_r == B_IDLE) && !empty;
    ram_we   = pop && head.kind == E_LOAD;
    ram_addr = ram_we ? head.addr
             : base_r + {{(STORE_AW-1){1'b0}}, cnt_r[0]} + (cnt_r[1] ? DY : '0)
               + (cnt_r[2] ? DZ : '0);
  end

  // one shared blend step per component; corners pair up as they arrive
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q[c] = ram_q[32*c +: 32];
    end
    unique case (cnt_r)
      4'd5:    begin la = x00_r; lb = x10_r; lf = fy_r; end
      4'd9:    begin la = x01_r; lb = x11_r; lf = fy_r; end
      4'd10:   begin la = y0_r;  lb = y1_r;  lf = fz_r; end
      default: begin la = hold_r; lb = q;    lf = fx_r; end
    endcase
    for (int c = 0; c < 3; c++) begin
      ly[c]      = lerp(la[c], lb[c], lf);
      shifted[c] = $signed(prod_r[c]) >>> 16;
      if (shifted[c][64:31] != {34{shifted[c][64]}}) begin
        sat[c] = shifted[c][64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        sat[c] = shifted[c][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        base_r <= head.addr;
        fx_r   <= head.fx;
        fy_r   <= head.fy;
        fz_r   <= head.fz;
        grid_r <= head.kind == E_QUERY;
        cnt_r  <= 4'd0;
      end
      B_RUN: begin
        cnt_r <= cnt_r + 4'd1;
        unique case (cnt_r)
          4'd1, 4'd3, 4'd7: hold_r <= q;
          4'd2:  x00_r <= ly;
          4'd4:  x10_r <= ly;
          4'd5:  begin y0_r <= ly; hold_r <= q; end
          4'd6:  x01_r <= ly;
          4'd8:  x11_r <= ly;
          4'd9:  y1_r <= ly;
          4'd10: v_r <= ly;
          default: ;
        endcase
      end
      B_SCALE: begin
        for (int c = 0; c < 3; c++) begin
          prod_r[c] <= $signed({{33{v_r[c][31]}}, v_r[c]}) * $signed({{32{neg_scale[32]}},
                                                                       neg_scale});
        end
      end
      B_OUT: begin
        if (out_free) res_r <= grid_r ? sat : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_OUT && out_free) out_in_grid <= grid_r;
  end

  assign out_valid   = out_valid_r;
  assign out_field_x = res_r[0];
  assign out_field_y = res_r[1];
  assign out_field_z = res_r[2];

endmodule
